/* src/swm_pkg.sv */
package swm_pkg;

    localparam int MAX_WINDOW_DEFAULT = 64;
    localparam int SAMPLE_W           = 32;
    localparam int WINDOW_SIZE_W      = 7;

    // control broadcast from the top level to every cell of the row
    typedef struct packed {
        logic step;   // a request is taken this cycle
        logic clear;  // window size written: empty the row
        logic start;  // first sample of a new array
        logic shift;  // front candidate has aged out, row moves one place left
    } t_cell_ctrl;

endpackage

/* src/swm_cell.sv */
module swm_cell #(
    parameter int AGE_W = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  swm_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_prev_keep,
    input  logic                                 i_nb_valid,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]  i_nb_value,
    input  logic        [AGE_W-1:0]              i_nb_age,
    output logic                                 o_valid,
    output logic signed [swm_pkg::SAMPLE_W-1:0]  o_value,
    output logic        [AGE_W-1:0]              o_age,
    output logic                                 o_keep,
    output logic signed [swm_pkg::SAMPLE_W-1:0]  o_next_value
);

    logic                                r_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_value;
    logic        [AGE_W-1:0]             r_age;

    logic                                n_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0] n_value;
    logic        [AGE_W-1:0]             n_age;

    logic                                src_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0] src_value;
    logic        [AGE_W-1:0]             src_age;
    logic                                keep;

    always_comb begin
        src_valid = i_ctrl.shift ? i_nb_valid : r_valid;
        src_value = i_ctrl.shift ? i_nb_value : r_value;
        src_age   = i_ctrl.shift ? i_nb_age   : r_age;

        // a candidate survives only if strictly larger than the new sample
        keep = src_valid && !i_ctrl.start && (src_value > i_sample);

        if (keep) begin
            n_valid = 1'b1;
            n_value = src_value;
            n_age   = src_age + AGE_W'(1);
        end else if (i_prev_keep) begin
            // first free place after the survivors takes the new sample
            n_valid = 1'b1;
            n_value = i_sample;
            n_age   = AGE_W'(1);
        end else begin
            n_valid = 1'b0;
            n_value = src_value;
            n_age   = src_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.step) begin
            r_valid <= n_valid;
        end
        if (i_ctrl.step) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_age        = r_age;
    assign o_keep       = keep;
    assign o_next_value = n_value;

endmodule

/* src/sliding_window_maximum_unit.sv */
// Sliding window maximum over a stream of signed 32-bit samples. One request is
// taken per clock cycle while o_stall is low; its result (if the window is full)
// goes to the output register, or to the skid stage while the output holds an
// earlier result, so the input keeps running; o_stall only rises once two results
// are held. The window is a row of MAX_WINDOW compare cells forming a monotonic
// candidate list: every request updates the whole row at once, which is what
// sets the one-sample-per-cycle figure. A start-of-array flag or a write of the
// window size empties the window; results resume once a full window has arrived.
// A window size of zero acts as one, and sizes above MAX_WINDOW act as MAX_WINDOW.
module sliding_window_maximum_unit #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]       i_sample,
    input  logic                                      i_start_of_array,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [swm_pkg::SAMPLE_W-1:0]       o_window_max,
    input  logic                                      i_cfg_wr_en,
    input  logic        [swm_pkg::WINDOW_SIZE_W-1:0]  i_cfg_wr_data
);

    localparam int AGE_W = $clog2(MAX_WINDOW + 1);

    logic        [swm_pkg::WINDOW_SIZE_W-1:0] r_window_size;
    logic        [AGE_W-1:0]                  r_fill;
    logic                                     r_out_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0]      r_out_data;
    logic                                     r_skid_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0]      r_skid_data;

    logic        [AGE_W-1:0]                  n_fill;
    logic        [AGE_W-1:0]                  w_eff;
    logic                                     accept;
    logic                                     result;
    logic                                     out_take;
    swm_pkg::t_cell_ctrl                      ctrl;

    logic        [MAX_WINDOW-1:0]             cell_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0]      cell_value [MAX_WINDOW];
    logic        [AGE_W-1:0]                  cell_age   [MAX_WINDOW];
    logic        [MAX_WINDOW-1:0]             cell_keep;
    logic signed [swm_pkg::SAMPLE_W-1:0]      cell_next  [MAX_WINDOW];

    always_comb begin
        if (r_window_size == '0) begin
            w_eff = AGE_W'(1);
        end else if (32'(r_window_size) > 32'(MAX_WINDOW)) begin
            w_eff = AGE_W'(MAX_WINDOW);
        end else begin
            w_eff = AGE_W'(r_window_size);
        end
    end

    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    always_comb begin
        ctrl.step  = accept;
        ctrl.clear = i_cfg_wr_en;
        ctrl.start = i_start_of_array;
        // positions advance by one per request, so at most the front can expire
        ctrl.shift = cell_valid[0] && (cell_age[0] >= w_eff);
    end

    always_comb begin
        if (i_start_of_array) begin
            n_fill = AGE_W'(1);
        end else if (r_fill < w_eff) begin
            n_fill = r_fill + AGE_W'(1);
        end else begin
            n_fill = r_fill;
        end
        result = accept && (n_fill >= w_eff);
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic                                nb_valid;
        logic signed [swm_pkg::SAMPLE_W-1:0] nb_value;
        logic        [AGE_W-1:0]             nb_age;
        logic                                prev_keep;

        if (g == MAX_WINDOW - 1) begin : g_tail
            assign nb_valid = 1'b0;
            assign nb_value = '0;
            assign nb_age   = '0;
        end else begin : g_body
            assign nb_valid = cell_valid[g+1];
            assign nb_value = cell_value[g+1];
            assign nb_age   = cell_age[g+1];
        end

        if (g == 0) begin : g_head
            assign prev_keep = 1'b1;
        end else begin : g_rest
            assign prev_keep = cell_keep[g-1];
        end

        swm_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_sample     (i_sample),
            .i_prev_keep  (prev_keep),
            .i_nb_valid   (nb_valid),
            .i_nb_value   (nb_value),
            .i_nb_age     (nb_age),
            .o_valid      (cell_valid[g]),
            .o_value      (cell_value[g]),
            .o_age        (cell_age[g]),
            .o_keep       (cell_keep[g]),
            .o_next_value (cell_next[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::WINDOW_SIZE_W'(1);
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window_size <= i_cfg_wr_data;
                r_fill        <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end

            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end
            end else if (result) begin
                if (!r_out_valid || out_take) begin
                    r_out_data  <= cell_next[0];
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_data  <= cell_next[0];
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_window_max = r_out_data;

`ifndef SYNTHESIS
    // skid stage only fills behind a held result
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result with the output register empty");

    a_fill_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_eff)
        else $error("fill count beyond the window length");

    // live candidates stay packed at the front of the row
    a_row_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid + MAX_WINDOW'(1)) & cell_valid) == '0)
        else $error("gap in the candidate row");

    a_front_young : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept) && !$past(i_cfg_wr_en) |-> cell_valid[0] && cell_age[0] <= w_eff)
        else $error("front candidate missing or older than the window");
`endif

endmodule

/* test/tb_sliding_window_maximum_unit.sv */
`timescale 1ns / 1ps

module tb_sliding_window_maximum_unit;

    localparam int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEFAULT;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD = 200;
    localparam logic signed [swm_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
        {1'b0, {(swm_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic signed [swm_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
        {1'b1, {(swm_pkg::SAMPLE_W-1){1'b0}}};

    typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_FALLING, PAT_RISING} t_pattern;

    logic                                      i_clk;
    logic                                      i_rst_n;
    logic                                      i_valid;
    logic                                      o_stall;
    logic signed [swm_pkg::SAMPLE_W-1:0]       i_sample;
    logic                                      i_start_of_array;
    logic                                      o_valid;
    logic                                      i_stall;
    logic signed [swm_pkg::SAMPLE_W-1:0]       o_window_max;
    logic                                      i_cfg_wr_en;
    logic        [swm_pkg::WINDOW_SIZE_W-1:0]  i_cfg_wr_data;

    // predictor state
    logic signed [swm_pkg::SAMPLE_W-1:0]       cand_val[$];
    logic        [15:0]                        cand_pos[$];
    logic        [15:0]                        next_pos = '0;
    int                                        fill_level = 0;
    logic        [swm_pkg::WINDOW_SIZE_W-1:0]  window_reg = 7'd1;
    logic signed [swm_pkg::SAMPLE_W-1:0]       expected_max[$];

    logic signed [swm_pkg::SAMPLE_W-1:0]       want_max;
    int                                        mismatch_count = 0;
    int                                        idle_cycles = 0;
    bit                                        tx_gaps_on = 1'b1;
    bit                                        rx_gaps_on = 1'b1;
    int                                        rx_hold_left = 0;
    int                                        rx_gap_left = 0;

    sliding_window_maximum_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .i_start_of_array (i_start_of_array),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_window_max     (o_window_max),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int eff_window();
        if (window_reg == 0) return 1;
        if (window_reg > MAX_WINDOW) return MAX_WINDOW;
        return int'(window_reg);
    endfunction

    // monotonic deque update for one accepted request
    function automatic void predict_window_max(
        input logic signed [swm_pkg::SAMPLE_W-1:0] s,
        input logic                                sop
    );
        int          w;
        logic [15:0] age;
        w = eff_window();
        if (sop) begin
            cand_val.delete();
            cand_pos.delete();
            fill_level = 0;
            next_pos = '0;
        end
        while (cand_val.size() > 0) begin
            age = next_pos - cand_pos[0];
            if (age < w) break;
            cand_val.delete(0);
            cand_pos.delete(0);
        end
        while (cand_val.size() > 0 && cand_val[$] <= s) begin
            cand_val.delete(cand_val.size() - 1);
            cand_pos.delete(cand_pos.size() - 1);
        end
        if (cand_val.size() >= MAX_WINDOW) begin
            cand_val.delete(0);
            cand_pos.delete(0);
        end
        cand_val = {cand_val, s};
        cand_pos = {cand_pos, next_pos};
        next_pos = next_pos + 16'd1;
        if (fill_level < w) fill_level++;
        if (fill_level >= w) expected_max = {expected_max, cand_val[0]};
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic signed [swm_pkg::SAMPLE_W-1:0] s,
                                input logic sop);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_sample         <= s;
        i_start_of_array <= sop;
        do @(posedge i_clk); while (o_stall);
        predict_window_max(s, sop);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_max.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_size(input logic [swm_pkg::WINDOW_SIZE_W-1:0] value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        window_reg = value;
        cand_val.delete();
        cand_pos.delete();
        fill_level = 0;
    endtask

    task automatic send_random_arrays(input int n_items);
        int                                  w;
        int                                  left;
        t_pattern                            pattern;
        logic signed [swm_pkg::SAMPLE_W-1:0] s;
        logic signed [swm_pkg::SAMPLE_W-1:0] prev;
        logic                                sop;
        w = eff_window();
        left = 0;
        pattern = PAT_RANDOM;
        prev = '0;
        repeat (n_items) begin
            sop = 1'b0;
            if (left == 0) begin
                sop = 1'b1;
                // mostly arrays that fill the window, some cut short
                left = ($urandom_range(0, 4) != 0) ? $urandom_range(w, 3 * w)
                                                   : $urandom_range(1, w);
                pattern = t_pattern'($urandom_range(0, 3));
                prev = $urandom;
            end
            case (pattern)
                PAT_RANDOM:  s = $urandom;
                PAT_NARROW:  s = $signed($urandom_range(0, 7)) - 4;
                PAT_FALLING: s = prev - $urandom_range(0, 3);
                default:     s = prev + $urandom_range(0, 3);
            endcase
            if ($urandom_range(0, 15) == 0) s = $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
            send_request(s, sop);
            prev = s;
            left--;
        end
    endtask

    task automatic test_reset_defaults();
        send_request(SAMPLE_MIN, 1'b1);
        send_request(SAMPLE_MAX, 1'b0);
        send_request(32'sd0, 1'b0);
        send_request(-32'sd1, 1'b0);
        send_request(32'sd1, 1'b0);
    endtask

    task automatic test_window_zero();
        write_window_size(7'd0);
        send_request(32'sd7, 1'b0);
        send_request(-32'sd7, 1'b0);
    endtask

    task automatic test_equal_and_restart();
        write_window_size(7'd3);
        send_request(32'sd10, 1'b1);
        send_request(32'sd10, 1'b0);
        send_request(32'sd10, 1'b0);
        send_request(32'sd9, 1'b0);
        send_request(32'sd8, 1'b0);
        // new array before the window has filled again
        send_request(32'sd1, 1'b1);
        send_request(32'sd2, 1'b0);
        send_request(32'sd3, 1'b0);
        send_request(32'sd2, 1'b0);
    endtask

    task automatic test_backpressure();
        int k;
        write_window_size(7'd4);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        rx_hold_left = LONG_HOLD;
        for (k = 0; k < 40; k++) send_request($urandom, k == 0);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_random_windows();
        logic [swm_pkg::WINDOW_SIZE_W-1:0] sizes[10];
        int                                k;
        sizes = '{7'd2, 7'd64, 7'd127, 7'd5, 7'd0, 7'd1, 7'd65, 7'd0, 7'd0, 7'd3};
        sizes[7] = swm_pkg::WINDOW_SIZE_W'($urandom_range(1, 127));
        sizes[8] = swm_pkg::WINDOW_SIZE_W'($urandom_range(1, 16));
        for (k = 0; k < 10; k++) begin
            write_window_size(sizes[k]);
            tx_gaps_on = (k % 3) != 1;
            rx_gaps_on = (k % 4) != 2;
            send_random_arrays((eff_window() > 16) ? 80 : 16);
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // one long array with long falling runs, so the row fills up
    task automatic test_long_array();
        logic signed [swm_pkg::SAMPLE_W-1:0] s;
        write_window_size(7'd64);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        s = '0;
        repeat (80) begin
            s = ($urandom_range(0, 99) == 0) ? $signed($urandom) : s - 1;
            send_request(s, 1'b0);
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // receiver: random stalls plus a long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left == 0 && rx_gap_left == 0 && rx_gaps_on
                && $urandom_range(0, 2) == 0)
                rx_gap_left = pick_gap();
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_stall <= 1'b1;
            end else if (rx_gap_left > 0) begin
                rx_gap_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_max.size() == 0) begin
                $error("window_max: expected no result, actual %0d", o_window_max);
                mismatch_count++;
            end else begin
                want_max = expected_max[0];
                expected_max.delete(0);
                if (o_window_max !== want_max) begin
                    $error("window_max: expected %0d, actual %0d", want_max, o_window_max);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_sample         <= '0;
        i_start_of_array <= 1'b0;
        i_cfg_wr_en      <= 1'b0;
        i_cfg_wr_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_window_zero();
        test_equal_and_restart();
        test_backpressure();
        test_random_windows();
        test_long_array();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
